// ----- src/mzbd_pkg.sv -----
// ----------------------------------------------------------------------------
// mzbd_pkg
// Types and constants shared by the m/z bin maximum decimator and its
// serial remainder unit.
// ----------------------------------------------------------------------------
package mzbd_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ColorW = 8;
  localparam int unsigned CfgIdxW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_BIN_WIDTH = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MZ_ORIGIN = 8'd1;

  // Reset values of the configuration registers.
  localparam logic [DataW-1:0] BinWidthReset = 32'h0001_0000;
  localparam logic [DataW-1:0] MzOriginReset = 32'h0000_0000;

  // Result actions.
  localparam logic ACT_APPEND  = 1'b0;
  localparam logic ACT_REPLACE = 1'b1;

  typedef struct packed {
    logic [DataW-1:0]  peak_id;
    logic [DataW-1:0]  mz;
    logic [DataW-1:0]  intensity;
    logic [DataW-1:0]  rt;
    logic [ColorW-1:0] color;
    logic              row_start;
    logic              new_layer;
  } peak_t;

  typedef struct packed {
    logic              action;
    logic [DataW-1:0]  kept_id;
    logic [DataW-1:0]  kept_mz;
    logic [DataW-1:0]  kept_intensity;
    logic [DataW-1:0]  kept_rt;
    logic [ColorW-1:0] kept_color;
    logic [DataW-1:0]  mz_lo;
    logic [DataW-1:0]  mz_hi;
    logic [DataW-1:0]  int_lo;
    logic [DataW-1:0]  int_hi;
    logic [DataW-1:0]  rt_lo;
    logic [DataW-1:0]  rt_hi;
  } result_t;

  // Handshake between the sequencer and the serial remainder unit.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } seq_state_t;

endpackage

// ----- src/mzbd_rem_div.sv -----
// ----------------------------------------------------------------------------
// mzbd_rem_div
// Restoring serial divider that produces the remainder of a 32-bit
// division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mzbd_rem_div
  import mzbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CntW = $clog2(DataW);

  logic [DataW-1:0] rem;
  logic [DataW-1:0] shreg;
  logic [DataW-1:0] divisor;
  logic [CntW-1:0]  cnt;
  logic             run;
  logic             done;

  logic [DataW:0]   rem_shift;
  logic [DataW-1:0] rem_next;

  // The partial remainder always stays below the divisor, so one compare
  // and subtract per bit is enough.
  always_comb begin
    rem_shift = {rem, shreg[DataW-1]};
    if (rem_shift >= {1'b0, divisor}) begin
      rem_next = rem_shift[DataW-1:0] - divisor;
    end else begin
      rem_next = rem_shift[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CntW'(1);
        if (cnt == CntW'(DataW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      shreg   <= req.dividend;
      divisor <= req.divisor;
    end else if (run) begin
      rem   <= rem_next;
      shreg <= {shreg[DataW-2:0], 1'b0};
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ----- src/mz_bin_max_decimator.sv -----
// ----------------------------------------------------------------------------
// mz_bin_max_decimator
// Keeps the strongest peak of each m/z bin within a retention-time row and
// reports the running m/z, intensity and time ranges of the kept peaks.
// ----------------------------------------------------------------------------
// Usage: peaks enter on in_valid/in_stall with in_data, sorted by m/z within
// each row; the first peak of a row carries row_start, and new_layer clears
// the running ranges before the peak is handled. Each peak yields either no
// item (a peak no stronger than the current bin's best) or one item on
// out_valid/out_stall: a replace when a stronger peak arrives in a bin that
// has already emitted, an append otherwise, as when the peak opens a new bin.
// Sequencing: a peak inside the current bin goes to S_EMIT on acceptance and
// its item is registered into the output from there. A peak beyond the bin
// bound first waits in S_DIV for the serial remainder unit, which works one
// bit per cycle, and then passes through S_EMIT. A weak peak is absorbed in
// the cycle it is accepted. Only one peak is in flight; the next is accepted
// once the current one has reached the output register, which holds its item
// while the receiver stalls, so the next peak may already be processed then;
// an item in S_EMIT waits while the held output is stalled.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is the bin width, index 1 the m/z origin, other indexes are
// ignored. A new origin takes effect at the next row start.
// Reset (rst, synchronous) restores the register defaults, sets the bound
// to the origin default and clears the running ranges; no clearing pass.
// ----------------------------------------------------------------------------
module mz_bin_max_decimator
  import mzbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  peak_t              in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output result_t            out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data
);

  // Configuration registers.
  logic [DataW-1:0] bin_width;
  logic [DataW-1:0] mz_origin;

  // Binning and range state.
  logic [DataW-1:0] bin_bound;
  logic [DataW-1:0] best_in_bin;
  logic             bin_emitted;
  logic [DataW-1:0] lo_mz_seen;
  logic [DataW-1:0] hi_mz_seen;
  logic [DataW-1:0] lo_int_seen;
  logic [DataW-1:0] hi_int_seen;
  logic [DataW-1:0] lo_rt_seen;
  logic [DataW-1:0] hi_rt_seen;

  // The peak in flight.
  seq_state_t       state;
  peak_t            held;
  logic             held_action;
  logic             held_new_bin;
  logic [DataW-1:0] pad;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             in_take;
  logic             emit;
  logic [DataW-1:0] width_eff;
  logic [DataW-1:0] bound_eff;
  logic [DataW-1:0] best_eff;
  logic             emitted_eff;
  logic             in_bin;
  logic [DataW:0]   bound_sum;
  logic [DataW-1:0] bound_next;
  logic [DataW-1:0] lo_mz_next;
  logic [DataW-1:0] hi_mz_next;
  logic [DataW-1:0] lo_int_next;
  logic [DataW-1:0] hi_int_next;
  logic [DataW-1:0] lo_rt_next;
  logic [DataW-1:0] hi_rt_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign emit      = (state == S_EMIT) && (!out_valid || !out_stall);

  // A zero bin width behaves as a width of one.
  assign width_eff = (bin_width == '0) ? DataW'(1) : bin_width;

  // A row start reloads the bound and forgets the bin's best peak.
  assign bound_eff   = in_data.row_start ? mz_origin : bin_bound;
  assign best_eff    = in_data.row_start ? '0 : best_in_bin;
  assign emitted_eff = in_data.row_start ? 1'b0 : bin_emitted;
  assign in_bin      = (in_data.mz <= bound_eff);

  // The new bound is the peak's m/z rounded up to the bin grid; it
  // saturates at the top of the range.
  assign bound_sum  = {1'b0, held.mz} + {1'b0, pad};
  assign bound_next = bound_sum[DataW] ? '1 : bound_sum[DataW-1:0];

  assign div_req.start    = in_take && !in_bin;
  assign div_req.dividend = in_data.mz - bound_eff;
  assign div_req.divisor  = width_eff;

  mzbd_rem_div u_rem_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Ranges with the held peak folded in; minimum and maximum independently.
  always_comb begin
    lo_mz_next  = (held.mz < lo_mz_seen) ? held.mz : lo_mz_seen;
    hi_mz_next  = (held.mz > hi_mz_seen) ? held.mz : hi_mz_seen;
    lo_int_next = (held.intensity < lo_int_seen) ? held.intensity : lo_int_seen;
    hi_int_next = (held.intensity > hi_int_seen) ? held.intensity : hi_int_seen;
    lo_rt_next  = (held.rt < lo_rt_seen) ? held.rt : lo_rt_seen;
    hi_rt_next  = (held.rt > hi_rt_seen) ? held.rt : hi_rt_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width <= BinWidthReset;
      mz_origin <= MzOriginReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIN_WIDTH: bin_width <= cfg_data;
        CFG_MZ_ORIGIN: mz_origin <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      bin_bound   <= MzOriginReset;
      best_in_bin <= '0;
      bin_emitted <= 1'b0;
      lo_mz_seen  <= '1;
      hi_mz_seen  <= '0;
      lo_int_seen <= '1;
      hi_int_seen <= '0;
      lo_rt_seen  <= '1;
      hi_rt_seen  <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (in_data.new_layer) begin
              lo_mz_seen  <= '1;
              hi_mz_seen  <= '0;
              lo_int_seen <= '1;
              hi_int_seen <= '0;
              lo_rt_seen  <= '1;
              hi_rt_seen  <= '0;
            end
            bin_bound   <= bound_eff;
            best_in_bin <= best_eff;
            bin_emitted <= emitted_eff;
            if (!in_bin) begin
              state <= S_DIV;
            end else if (in_data.intensity > best_eff) begin
              state <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            state       <= S_IDLE;
            out_valid   <= 1'b1;
            best_in_bin <= held.intensity;
            bin_emitted <= 1'b1;
            lo_mz_seen  <= lo_mz_next;
            hi_mz_seen  <= hi_mz_next;
            lo_int_seen <= lo_int_next;
            hi_int_seen <= hi_int_next;
            lo_rt_seen  <= lo_rt_next;
            hi_rt_seen  <= hi_rt_next;
            if (held_new_bin) begin
              bin_bound <= bound_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      held         <= in_data;
      held_new_bin <= !in_bin;
      held_action  <= (in_bin && emitted_eff) ? ACT_REPLACE : ACT_APPEND;
    end
    if (div_rsp.done) begin
      pad <= (div_rsp.remainder == '0) ? '0 : width_eff - div_rsp.remainder;
    end
    if (emit) begin
      out_data.action         <= held_action;
      out_data.kept_id        <= held.peak_id;
      out_data.kept_mz        <= held.mz;
      out_data.kept_intensity <= held.intensity;
      out_data.kept_rt        <= held.rt;
      out_data.kept_color     <= held.color;
      out_data.mz_lo          <= lo_mz_next;
      out_data.mz_hi          <= hi_mz_next;
      out_data.int_lo         <= lo_int_next;
      out_data.int_hi         <= hi_int_next;
      out_data.rt_lo          <= lo_rt_next;
      out_data.rt_hi          <= hi_rt_next;
    end
  end

`ifndef ASSERT_OFF
  // A new item only appears on the output from the emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("output item appeared without an emit step");

  // The remainder unit only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  // The kept m/z always lies within the reported m/z range.
  a_mz_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.mz_lo <= out_data.kept_mz) &&
                  (out_data.kept_mz <= out_data.mz_hi))
    else $error("kept m/z outside the reported range");

  // A new bin always ends with its bound at or above the peak's m/z.
  a_bound_covers: assert property (@(posedge clk) disable iff (rst)
    (emit && held_new_bin) |=> (bin_bound >= $past(held.mz)))
    else $error("advanced bin bound below the peak m/z");
`endif

endmodule

// ----- tb/mz_bin_max_decimator_checker.sv -----
// ----------------------------------------------------------------------------
// mz_bin_max_decimator_checker
// Watches the peak, result and register channels of the decimator, predicts
// the kept peaks and their running ranges, and compares every result item
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mz_bin_max_decimator_checker
  import mzbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  peak_t              in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  result_t            out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  output int                 failures,
  output int                 pending,
  output int                 checked
);

  logic [DataW-1:0] bin_width_q;
  logic [DataW-1:0] mz_origin_q;
  logic [DataW-1:0] bound_q;
  logic [DataW-1:0] best_q;
  logic             emitted_q;
  logic [DataW-1:0] mz_lo_q, mz_hi_q, int_lo_q, int_hi_q, rt_lo_q, rt_hi_q;

  result_t kept_queue[$];
  result_t want;

  function void clear_ranges();
    mz_lo_q  = '1;
    mz_hi_q  = '0;
    int_lo_q = '1;
    int_hi_q = '0;
    rt_lo_q  = '1;
    rt_hi_q  = '0;
  endfunction

  // Works out what one accepted peak does to the state and queues the
  // result item it causes, if any.
  function void keep_strongest(input peak_t p);
    logic [63:0] w, gap, steps, nb;
    result_t r;
    if (p.new_layer) clear_ranges();
    if (p.row_start) begin
      bound_q   = mz_origin_q;
      best_q    = '0;
      emitted_q = 1'b0;
    end
    if (p.mz <= bound_q) begin
      // Inside the current bin only a strictly stronger peak survives.
      if (p.intensity <= best_q) return;
      r.action = emitted_q ? ACT_REPLACE : ACT_APPEND;
    end else begin
      // Advance by whole bin widths; a zero width moves the bound to mz.
      w       = (bin_width_q == '0) ? 64'd1 : {32'd0, bin_width_q};
      gap     = {32'd0, p.mz} - {32'd0, bound_q};
      steps   = (gap + w - 64'd1) / w;
      nb      = {32'd0, bound_q} + steps * w;
      bound_q = (nb > 64'h0000_0000_FFFF_FFFF) ? '1 : nb[DataW-1:0];
      r.action = ACT_APPEND;
    end
    best_q    = p.intensity;
    emitted_q = 1'b1;
    if (p.mz < mz_lo_q) mz_lo_q = p.mz;
    if (p.mz > mz_hi_q) mz_hi_q = p.mz;
    if (p.intensity < int_lo_q) int_lo_q = p.intensity;
    if (p.intensity > int_hi_q) int_hi_q = p.intensity;
    if (p.rt < rt_lo_q) rt_lo_q = p.rt;
    if (p.rt > rt_hi_q) rt_hi_q = p.rt;
    r.kept_id        = p.peak_id;
    r.kept_mz        = p.mz;
    r.kept_intensity = p.intensity;
    r.kept_rt        = p.rt;
    r.kept_color     = p.color;
    r.mz_lo          = mz_lo_q;
    r.mz_hi          = mz_hi_q;
    r.int_lo         = int_lo_q;
    r.int_hi         = int_hi_q;
    r.rt_lo          = rt_lo_q;
    r.rt_hi          = rt_hi_q;
    kept_queue = {kept_queue, r};
  endfunction

  function void check_field(input string name, input logic [DataW-1:0] exp_v,
                            input logic [DataW-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      failures++;
    end
  endfunction

  initial begin
    failures = 0;
    pending  = 0;
    checked  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      bin_width_q = BinWidthReset;
      mz_origin_q = MzOriginReset;
      bound_q     = MzOriginReset;
      best_q      = '0;
      emitted_q   = 1'b0;
      clear_ranges();
      kept_queue.delete();
    end else begin
      // The result leaving now always belongs to an earlier peak, so it is
      // compared before a peak accepted at this same edge is predicted.
      if (out_valid && !out_stall) begin
        if (kept_queue.size() == 0) begin
          $error("result item with no prediction waiting: kept_id %h", out_data.kept_id);
          failures++;
        end else begin
          want = kept_queue.pop_front();
          check_field("action", DataW'(want.action), DataW'(out_data.action));
          check_field("kept_id", want.kept_id, out_data.kept_id);
          check_field("kept_mz", want.kept_mz, out_data.kept_mz);
          check_field("kept_intensity", want.kept_intensity, out_data.kept_intensity);
          check_field("kept_rt", want.kept_rt, out_data.kept_rt);
          check_field("kept_color", DataW'(want.kept_color), DataW'(out_data.kept_color));
          check_field("mz_lo", want.mz_lo, out_data.mz_lo);
          check_field("mz_hi", want.mz_hi, out_data.mz_hi);
          check_field("int_lo", want.int_lo, out_data.int_lo);
          check_field("int_hi", want.int_hi, out_data.int_hi);
          check_field("rt_lo", want.rt_lo, out_data.rt_lo);
          check_field("rt_hi", want.rt_hi, out_data.rt_hi);
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BIN_WIDTH: bin_width_q = cfg_data;
          CFG_MZ_ORIGIN: mz_origin_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) keep_strongest(in_data);
    end
    pending = kept_queue.size();
  end

endmodule

// ----- tb/mz_bin_max_decimator_test.sv -----
// ----------------------------------------------------------------------------
// mz_bin_max_decimator_test
// Drives the decimator with a short directed run of peaks and then with
// mostly sorted rows of peaks under several bin settings, while random gaps and
// stalls fall on both channels; the checker beside the block compares every
// result item and this module gives the verdict.
// ----------------------------------------------------------------------------
module mz_bin_max_decimator_test;
  import mzbd_pkg::*;

  // Far above the slowest legal run: about 1400 peaks, plus the quiet
  // periods around each register write.
  localparam int CycleLimit = 400000;
  // Cycles allowed after the last expected item before the block counts as
  // idle.
  localparam int SettleCycles = 40;
  localparam int PhaseItems   = 225;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  peak_t              in_data;
  logic               out_valid;
  logic               out_stall;
  result_t            out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_data;

  int failures;
  int pending;
  int checked;
  int peaks_sent;
  int writes_done;
  int cycles;
  // When set, neither side inserts gaps or stalls, so back-to-back items
  // are exercised as well.
  logic steady;

  mz_bin_max_decimator u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mz_bin_max_decimator_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run ends here if the results stop coming.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side: unless steady is set, the receiver may stall before each item;
  // it then holds its stall low until an item has actually been taken.
  initial begin : result_stalls
    int n;
    out_stall = 1'b0;
    forever begin
      n = steady ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b);
    logic [DataW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DataW] ? '1 : s[DataW-1:0];
  endfunction

  // A peak with the given position, strength and flags; the fields that are
  // merely passed through are random.
  function automatic peak_t peak_of(input logic [DataW-1:0] mz,
                                    input logic [DataW-1:0] inten,
                                    input logic rs, input logic nl);
    peak_t p;
    p.peak_id   = $urandom;
    p.mz        = mz;
    p.intensity = inten;
    p.rt        = $urandom;
    p.color     = $urandom_range(0, 255);
    p.row_start = rs;
    p.new_layer = nl;
    return p;
  endfunction

  // Presents one peak after a random gap and returns once it is accepted.
  // Valid stays high afterwards; the next call or wait_idle decides.
  task automatic send_peak(input peak_t p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (in_stall);
    peaks_sent++;
  endtask

  // Waits until every predicted item has come out, then waits SettleCycles
  // more before returning.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] d);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    writes_done++;
  endtask

  // One setting of the registers followed by random traffic: mostly rows of
  // peaks sorted by m/z with steps of up to a third of a bin, so that bins
  // take several peaks and both appends and replaces are frequent; the rest
  // is unsorted noise with random flags.
  task automatic run_phase(input logic [DataW-1:0] width, input logic [DataW-1:0] origin);
    int sent, len, k;
    logic [DataW-1:0] step, mz, d, inten;
    peak_t p;
    write_reg(CFG_BIN_WIDTH, width);
    write_reg(CFG_MZ_ORIGIN, origin);
    step = (width / 3 == 0) ? 1 : width / 3;
    sent = 0;
    while (sent < PhaseItems) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 16);
        d   = $urandom_range(0, step);
        case ($urandom_range(0, 3))
          0:       mz = $urandom;
          1:       mz = (origin > d) ? origin - d : '0;
          default: mz = sat_add(origin, d);
        endcase
        for (k = 0; k < len; k++) begin
          inten = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
          p = peak_of(mz, inten, k == 0,
                      (k == 0) ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 30) == 0));
          send_peak(p);
          sent++;
          mz = sat_add(mz, $urandom_range(0, step));
        end
      end else begin
        p = peak_of($urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
        send_peak(p);
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    peak_t p;
    logic [DataW-1:0] widths[6];
    logic [DataW-1:0] origins[6];
    int i;

    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    steady      = 1'b0;
    peaks_sent  = 0;
    writes_done = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, default registers. No row start has been seen yet, so
    // the bound is still zero: an append, a replace, then a weak peak.
    p = peak_of('0, 32'd5, 1'b0, 1'b0);
    p.peak_id = '0;
    p.rt      = '0;
    p.color   = '0;
    send_peak(p);
    send_peak(peak_of('0, 32'd9, 1'b0, 1'b0));
    send_peak(peak_of('0, 32'd3, 1'b0, 1'b0));
    send_peak(peak_of(32'h0001_8000, 32'd2, 1'b0, 1'b0));
    // All-ones peak: the advanced bound passes the top of the range and
    // must saturate.
    p = peak_of('1, '1, 1'b0, 1'b0);
    p.peak_id = '1;
    p.rt      = '1;
    p.color   = '1;
    send_peak(p);
    // Row start with a layer clear and a zero-intensity peak at the origin:
    // nothing is kept, but the clears still happen.
    send_peak(peak_of('0, '0, 1'b1, 1'b1));
    send_peak(peak_of(32'h0000_0010, 32'd1, 1'b1, 1'b1));

    // Zero bin width behaves as width one; writes to unknown indexes must
    // change nothing.
    write_reg(CFG_BIN_WIDTH, '0);
    write_reg(CFG_MZ_ORIGIN + 8'd1, '1);
    write_reg('1, '1);
    send_peak(peak_of(32'h0000_0100, 32'd1, 1'b1, 1'b0));
    send_peak(peak_of(32'h0000_0100, 32'd2, 1'b0, 1'b0));
    send_peak(peak_of(32'h0000_0101, 32'd1, 1'b0, 1'b0));
    send_peak(peak_of(32'h0000_0101, 32'd1, 1'b0, 1'b0));

    // Widest bin and highest origin. The new origin only counts from the
    // next row start; before that the bound saturates on its first step.
    write_reg(CFG_BIN_WIDTH, '1);
    write_reg(CFG_MZ_ORIGIN, '1);
    send_peak(peak_of(32'h0000_0200, 32'd4, 1'b0, 1'b0));
    send_peak(peak_of('1, 32'd7, 1'b1, 1'b0));
    send_peak(peak_of('1, 32'd8, 1'b0, 1'b0));

    // Narrowest bin: a zero-intensity peak opening a bin is still kept.
    write_reg(CFG_BIN_WIDTH, 32'd1);
    write_reg(CFG_MZ_ORIGIN, '0);
    send_peak(peak_of('0, '0, 1'b1, 1'b1));
    send_peak(peak_of(32'd1, '0, 1'b0, 1'b0));
    send_peak(peak_of(32'd1, '0, 1'b0, 1'b0));
    send_peak(peak_of(32'd5, '1, 1'b0, 1'b0));

    // Random part over several settings, the extremes among them.
    widths  = '{32'h0001_0000, 32'd1, 32'hFFFF_FFFF, $urandom, 32'h0000_4000, 32'd0};
    origins = '{32'd0, 32'd0, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, 32'h0001_2345};
    for (i = 0; i < 6; i++) run_phase(widths[i], origins[i]);

    wait_idle();
    $display("Sent %0d peaks under %0d register writes; %0d result items were compared.",
             peaks_sent, writes_done, checked);
    $display("Bin widths from zero to all ones and origins from zero to all ones were used.");
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mzbd_pkg.sv
src/mzbd_rem_div.sv
src/mz_bin_max_decimator.sv
tb/mz_bin_max_decimator_checker.sv
tb/mz_bin_max_decimator_test.sv
